### hw/rtl/lrr_pkg.sv
// Shared types and constants for the ranged Lehmer generator.
`default_nettype none

package lrr_pkg;

  localparam int unsigned WORD_W = 32;

  // Park-Miller multiplier, fits in 15 bits
  localparam logic [14:0] LCG_MULT = 15'd16807;

  // State after reset, same as after seeding with zero
  localparam logic [WORD_W-1:0] GEN_RESET = 32'd1;

  // Command codes; HOLD leaves the state untouched and reports it
  typedef enum logic [1:0] {
    CMD_RESEED = 2'd0,
    CMD_DRAW   = 2'd1,
    CMD_RANGED = 2'd2,
    CMD_HOLD   = 2'd3
  } lrr_cmd_t;

  // One job passed from the front to the back
  typedef struct packed {
    lrr_cmd_t          cmd;
    logic [WORD_W-1:0] raw;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] span;
  } lrr_job_t;

endpackage

`default_nettype wire

### hw/rtl/lrr_in_if.sv
// Command channel: valid/ready handshake with the command payload.
`default_nettype none

interface lrr_in_if;
  import lrr_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [WORD_W-1:0]  seed_value;
  logic signed [WORD_W-1:0] range_low;
  logic signed [WORD_W-1:0] range_high;

  modport source (
    output valid, cmd, seed_value, range_low, range_high,
    input  ready
  );

  modport sink (
    input  valid, cmd, seed_value, range_low, range_high,
    output ready
  );

endinterface

`default_nettype wire

### hw/rtl/lrr_out_if.sv
// Result channel: valid/ready handshake with the result payload.
`default_nettype none

interface lrr_out_if;
  import lrr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [WORD_W-1:0]        raw_value;
  logic signed [WORD_W-1:0] ranged_value;
  logic                     range_error;

  modport source (
    output valid, raw_value, ranged_value, range_error,
    input  ready
  );

  modport sink (
    input  valid, raw_value, ranged_value, range_error,
    output ready
  );

endinterface

`default_nettype wire

### hw/rtl/lehmer_random_ranged.sv
// Top level of the ranged Lehmer random generator.
`default_nettype none

// Park-Miller generator (multiplier 16807, modulus 2^31-1) with reseed, raw
// draw and ranged draw commands, one result per command. The front end
// accepts a command whenever it is idle and keeps in_chan.ready low until the
// job is in the queue: a reseed or the unused code goes straight to the push
// state, while a draw or ranged draw first passes the split multiply (F_MUL)
// and the fold (F_SUM). The back end pops a reseed, plain draw or unused code
// and then loads the result register; a ranged draw with nonzero span is
// popped and started, runs 32 steps of the radix-2 remainder unit that retires
// one bit per cycle, takes the remainder and is then loaded; the result can
// transfer from the cycle after the load. A job queue of QUEUE_DEPTH entries
// between the two lets raw draws and reseeds keep coming in while a ranged
// draw is still being reduced, and the result register lets the next job
// run while a result waits.
module lehmer_random_ranged #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire          clk,
  input  wire          rst_n,
  lrr_in_if.sink       in_chan,
  lrr_out_if.source    out_chan
);
  import lrr_pkg::*;

  logic     q_push;
  lrr_job_t q_push_data;
  logic     q_full;
  logic     q_pop;
  lrr_job_t q_pop_data;
  logic     q_empty;

  lrr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .push      (q_push),
    .push_data (q_push_data),
    .q_full    (q_full)
  );

  lrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  lrr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_pop_data),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

### hw/rtl/lrr_front.sv
// Front end: takes commands, updates the generator word, queues jobs.
`default_nettype none

module lrr_front (
  input  wire                  clk,
  input  wire                  rst_n,
  lrr_in_if.sink               in_chan,
  output logic                 push,
  output lrr_pkg::lrr_job_t    push_data,
  input  wire                  q_full
);
  import lrr_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_PUSH
  } fstate_t;

  fstate_t           state_r;
  lrr_cmd_t          cmd_r;
  logic [WORD_W-1:0] gen_r;
  logic [WORD_W-1:0] low_r;
  logic [WORD_W-1:0] span_r;
  logic [30:0]       prod_lo_r;
  logic [30:0]       prod_hi_r;

  logic              in_xfer;
  lrr_cmd_t          in_cmd;
  logic [WORD_W-1:0] span_nxt;
  logic [WORD_W-1:0] seed_nxt;
  logic [30:0]       prod_lo_nxt;
  logic [30:0]       prod_hi_nxt;
  logic [WORD_W-1:0] fold_sum;
  logic [WORD_W-1:0] gen_nxt;

  assign in_chan.ready = (state_r == F_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign in_cmd        = lrr_cmd_t'(in_chan.cmd);

  // Wrapped span, read as unsigned
  assign span_nxt = WORD_W'(in_chan.range_high) - WORD_W'(in_chan.range_low);

  // Reseed: all ones maps to the reset word, else seed plus one
  assign seed_nxt = (in_chan.seed_value == '1) ? GEN_RESET
                                               : in_chan.seed_value + 32'd1;

  // Split multiply of both halves by the constant multiplier
  assign prod_lo_nxt = {15'h0, gen_r[15:0]} * {16'h0, LCG_MULT};
  assign prod_hi_nxt = {15'h0, gen_r[31:16]} * {16'h0, LCG_MULT};

  // Fold the high product back in and reduce modulo 2^31-1
  assign fold_sum = {1'b0, prod_lo_r}
                  + {1'b0, prod_hi_r[14:0], 16'h0}
                  + {16'h0, prod_hi_r[30:15]};
  assign gen_nxt  = {1'b0, fold_sum[30:0]} + {31'h0, fold_sum[31]};

  // Hand the finished job to the queue
  assign push           = (state_r == F_PUSH) && !q_full;
  assign push_data.cmd  = cmd_r;
  assign push_data.raw  = gen_r;
  assign push_data.low  = low_r;
  assign push_data.span = span_r;

  // Sequence one command through push, with multiply and fold first for draws
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      gen_r   <= GEN_RESET;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_xfer) begin
            cmd_r  <= in_cmd;
            low_r  <= WORD_W'(in_chan.range_low);
            span_r <= span_nxt;
            case (in_cmd)
              CMD_RESEED: begin
                gen_r   <= seed_nxt;
                state_r <= F_PUSH;
              end
              CMD_DRAW, CMD_RANGED: begin
                state_r <= F_MUL;
              end
              default: begin
                state_r <= F_PUSH;
              end
            endcase
          end
        end
        F_MUL: begin
          prod_lo_r <= prod_lo_nxt;
          prod_hi_r <= prod_hi_nxt;
          state_r   <= F_SUM;
        end
        F_SUM: begin
          gen_r   <= gen_nxt;
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_chan.ready)
    else $error("front took a second command while still busy");

  a_reseed_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_cmd == CMD_RESEED) && (in_chan.seed_value == '1))
      |=> (gen_r == GEN_RESET))
    else $error("all-ones reseed did not load the reset word");
`endif

endmodule

`default_nettype wire

### hw/rtl/lrr_queue.sv
// Small job queue between the front and the back.
`default_nettype none

module lrr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  lrr_pkg::lrr_job_t    push_data,
  output logic                 full,
  input  wire                  pop,
  output lrr_pkg::lrr_job_t    pop_data,
  output logic                 empty
);
  import lrr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lrr_job_t          slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);

  // Store an entry on push
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(DEPTH)) && !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");
`endif

endmodule

`default_nettype wire

### hw/rtl/lrr_rem_unit.sv
// Radix-2 restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module lrr_rem_unit (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire  [lrr_pkg::WORD_W-1:0]    dividend,
  input  wire  [lrr_pkg::WORD_W-1:0]    divisor,
  output logic                          done,
  output logic [lrr_pkg::WORD_W-1:0]    remainder
);
  import lrr_pkg::*;

  localparam int unsigned STEP_W = $clog2(WORD_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] dvd_r;
  logic [WORD_W-1:0] dsr_r;

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic              fits;
  logic [WORD_W-1:0] rem_nxt;

  // Bring in the next dividend bit and try a subtract
  assign shifted = {rem_r, dvd_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign fits    = (shifted >= {1'b0, dsr_r});
  assign rem_nxt = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];

  assign done      = done_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        dvd_r  <= {dvd_r[WORD_W-2:0], 1'b0};
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lrr_back.sv
// Back end: pops jobs, reduces ranged draws, holds the result register.
`default_nettype none

module lrr_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_empty,
  input  lrr_pkg::lrr_job_t    q_data,
  output logic                 pop,
  lrr_out_if.source            out_chan
);
  import lrr_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } bstate_t;

  bstate_t           state_r;
  lrr_job_t          job_r;
  logic [WORD_W-1:0] res_ranged_r;
  logic              res_err_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_raw_r;
  logic [WORD_W-1:0] out_ranged_r;
  logic              out_err_r;

  logic              is_ranged;
  logic              span_zero;
  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_rem;
  logic              out_free;
  logic              out_load;

  assign is_ranged = (q_data.cmd == CMD_RANGED);
  assign span_zero = (q_data.span == '0);
  assign pop       = (state_r == B_IDLE) && !q_empty;
  assign div_start = pop && is_ranged && !span_zero;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign out_load  = (state_r == B_DONE) && out_free;

  lrr_rem_unit u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (q_data.raw),
    .divisor   (q_data.span),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign out_chan.valid        = out_valid_r;
  assign out_chan.raw_value    = out_raw_r;
  assign out_chan.ranged_value = out_ranged_r;
  assign out_chan.range_error  = out_err_r;

  // Run each job and load the result register when it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result, or drop the old one once its transfer completes
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (pop) begin
            job_r <= q_data;
            if (div_start) begin
              state_r <= B_DIV;
            end else begin
              res_ranged_r <= is_ranged ? q_data.low : '0;
              res_err_r    <= is_ranged && span_zero;
              state_r      <= B_DONE;
            end
          end
        end
        B_DIV: begin
          if (div_done) begin
            res_ranged_r <= div_rem + job_r.low;
            res_err_r    <= 1'b0;
            state_r      <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_raw_r    <= job_r.raw;
            out_ranged_r <= res_ranged_r;
            out_err_r    <= res_err_r;
            state_r      <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == B_DIV))
    else $error("remainder finished outside of a ranged draw");

  a_err_needs_ranged: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DONE && res_err_r) |-> (job_r.cmd == CMD_RANGED && job_r.span == '0))
    else $error("range error flagged for a job without zero span");
`endif

endmodule

`default_nettype wire

### sim/lrr_checker.sv
// Checker for the ranged Lehmer generator: predicts each result and compares it.
`default_nettype none

module lrr_checker (
  input  wire        clk,
  input  wire        rst_n,
  lrr_in_if          cmd_mon,
  lrr_out_if         res_mon,
  output int         fail_count,
  output int         outstanding
);
  import lrr_pkg::*;

  localparam logic [31:0] PM_MULT = 32'd16807;
  localparam int          PRINT_CAP = 40;

  typedef struct packed {
    logic [31:0] raw;
    logic [31:0] ranged;
    logic        err;
  } lrr_result_t;

  // Results predicted for accepted commands, oldest first
  lrr_result_t pending_results[$];
  lrr_result_t want;
  lrr_result_t got;
  logic [31:0] gen_word;
  int          mismatch_total = 0;

  assign fail_count = mismatch_total;

  initial outstanding = 0;

  // One Park-Miller step with the split multiply and the fold at bit 31
  function automatic logic [31:0] lehmer_advance(input logic [31:0] s);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = PM_MULT * {16'd0, s[15:0]};
    hi = PM_MULT * {16'd0, s[31:16]};
    lo = lo + {1'b0, hi[14:0], 16'd0};
    lo = lo + {15'd0, hi[31:15]};
    return {1'b0, lo[30:0]} + {31'd0, lo[31]};
  endfunction

  // Print one line (up to a cap) and count the mismatch
  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    if (mismatch_total < PRINT_CAP)
      $display("mismatch on %s: got %h, want %h, at %0t", what, seen, wanted, $time);
    mismatch_total++;
  endtask

  // Update the generator word for one command and queue its result
  task automatic predict_result(input logic [1:0] cmd_bits, input logic [31:0] seed,
                                input logic [31:0] low, input logic [31:0] high);
    lrr_result_t r;
    logic [31:0] span;
    r.ranged = 32'd0;
    r.err    = 1'b0;
    span     = high - low;
    case (lrr_cmd_t'(cmd_bits))
      CMD_RESEED: begin
        gen_word = (seed == 32'hFFFF_FFFF) ? GEN_RESET : seed + 32'd1;
      end
      CMD_DRAW: begin
        gen_word = lehmer_advance(gen_word);
      end
      CMD_RANGED: begin
        gen_word = lehmer_advance(gen_word);
        if (span == 32'd0) begin
          r.err    = 1'b1;
          r.ranged = low;
        end else begin
          r.ranged = (gen_word % span) + low;
        end
      end
      default: begin
        // hold: state unchanged
      end
    endcase
    r.raw = gen_word;
    pending_results.push_back(r);
  endtask

  // Watch both channels; check outgoing transfers before queuing new ones
  always @(posedge clk) begin
    if (!rst_n) begin
      gen_word = GEN_RESET;
      pending_results.delete();
    end else begin
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) begin
        got.raw    = res_mon.raw_value;
        got.ranged = res_mon.ranged_value;
        got.err    = res_mon.range_error;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result raw_value", got.raw, 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.raw !== want.raw)
            report_mismatch("raw_value", got.raw, want.raw);
          if (got.ranged !== want.ranged)
            report_mismatch("ranged_value", got.ranged, want.ranged);
          if (got.err !== want.err)
            report_mismatch("range_error", {31'd0, got.err}, {31'd0, want.err});
        end
      end
      if (cmd_mon.valid === 1'b1 && cmd_mon.ready === 1'b1)
        predict_result(cmd_mon.cmd, cmd_mon.seed_value, cmd_mon.range_low,
                       cmd_mon.range_high);
    end
    outstanding <= pending_results.size();
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench top for the ranged Lehmer generator: stimulus, result sink and verdict.
`default_nettype none

module tb_top;
  import lrr_pkg::*;

  localparam int RANDOM_ITEMS  = 1500;
  localparam int MAX_GAP       = 18;
  localparam int PRESSURE_AT   = 150;
  localparam int PRESSURE_LEN  = 500;
  localparam int DRAIN_CYCLES  = 64;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   cmds_sent = 0;
  int   results_taken = 0;
  bit   hold_off = 1'b0;
  bit   pressure_done = 1'b0;

  lrr_in_if  cmd_chan ();
  lrr_out_if res_chan ();

  lehmer_random_ranged DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cmd_chan),
    .out_chan (res_chan)
  );

  lrr_checker CHK (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_mon     (cmd_chan),
    .res_mon     (res_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one command after a random gap and hold it until the transfer
  task automatic send_command(input lrr_cmd_t c, input logic [31:0] seed,
                              input logic [31:0] low, input logic [31:0] high);
    int gap;
    if (hold_off || ((cmds_sent / 50) % 4 == 2))
      gap = 0;
    else
      gap = $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      cmd_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_chan.valid      <= 1'b1;
    cmd_chan.cmd        <= c;
    cmd_chan.seed_value <= seed;
    cmd_chan.range_low  <= low;
    cmd_chan.range_high <= high;
    do @(posedge clk); while (!(cmd_chan.valid === 1'b1 && cmd_chan.ready === 1'b1));
    cmds_sent++;
  endtask

  // Draw one random command; most are draws and ranged draws
  task automatic send_random_command();
    int          pick;
    int          mode;
    lrr_cmd_t    c;
    logic [31:0] seed;
    logic [31:0] low;
    logic [31:0] high;
    pick = $urandom_range(0, 99);
    seed = $urandom;
    low  = $urandom;
    high = $urandom;
    if (pick < 10) begin
      c = CMD_RESEED;
      mode = $urandom_range(0, 7);
      if (mode == 0) seed = 32'hFFFF_FFFF;
      else if (mode == 1) seed = 32'hFFFF_FFFE;
      else if (mode == 2) seed = 32'd0;
      else if (mode == 3) seed = 32'h7FFF_FFFF;
    end else if (pick < 40) begin
      c = CMD_DRAW;
    end else if (pick < 95) begin
      c = CMD_RANGED;
      mode = $urandom_range(0, 5);
      case (mode)
        0: high = low + $urandom_range(1, 16);
        1: high = low;
        2: ;
        3: high = low + (32'd1 << $urandom_range(0, 31));
        4: high = low - $urandom_range(1, 16);
        default: begin
          low  = -$urandom_range(0, 100);
          high = $urandom_range(0, 100);
        end
      endcase
    end else begin
      c = CMD_HOLD;
    end
    send_command(c, seed, low, high);
  endtask

  // Stimulus: reset, directed corners, random commands, drain, verdict
  initial begin
    cmd_chan.valid      <= 1'b0;
    cmd_chan.cmd        <= CMD_HOLD;
    cmd_chan.seed_value <= 32'd0;
    cmd_chan.range_low  <= 32'd0;
    cmd_chan.range_high <= 32'd0;
    rst_n               <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Draws straight from the reset state
    send_command(CMD_DRAW,   32'd0, 32'd0, 32'd0);
    send_command(CMD_RANGED, 32'd0, 32'd0, 32'd10);
    // Reseed corners, including states outside the normal cycle
    send_command(CMD_RESEED, 32'd0,          32'd0, 32'd0);
    send_command(CMD_RESEED, 32'hFFFF_FFFF,  32'd0, 32'd0);
    send_command(CMD_DRAW,   32'hFFFF_FFFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_RESEED, 32'hFFFF_FFFE,  32'd0, 32'd0);
    send_command(CMD_DRAW,   32'd0,          32'd0, 32'd0);
    send_command(CMD_RESEED, 32'h7FFF_FFFE,  32'd0, 32'd0);
    send_command(CMD_DRAW,   32'd0,          32'd0, 32'd0);
    send_command(CMD_RESEED, 32'h7FFF_FFFF,  32'd0, 32'd0);
    // Zero span at both extremes of the bound
    send_command(CMD_RANGED, 32'd0, 32'h8000_0000, 32'h8000_0000);
    send_command(CMD_RANGED, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // Inverted, overflowing and unit spans
    send_command(CMD_RANGED, 32'd0, 32'd100, -32'sd100);
    send_command(CMD_RANGED, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_command(CMD_RANGED, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_command(CMD_RANGED, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_command(CMD_RANGED, 32'd0, 32'd0, 32'hFFFF_FFFF);
    // Unused command code leaves the state alone
    send_command(CMD_HOLD,   32'd0, 32'd0, 32'd0);
    send_command(CMD_HOLD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_RESEED, 32'h1234_5677, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_RANGED, 32'hFFFF_FFFF, 32'd0, 32'd1);
    send_command(CMD_RESEED, 32'h0000_FFFF, 32'd0, 32'd0);
    send_command(CMD_DRAW,   32'd0, 32'd0, 32'd0);

    repeat (RANDOM_ITEMS) send_random_command();
    cmd_chan.valid <= 1'b0;
    // let the checker count the last transfer before draining
    @(posedge clk);

    // Drain every expected result, then let the block settle
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Result sink: random hold-offs, bursts of steady ready, one long stall
  initial begin
    int k;
    res_chan.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!pressure_done && results_taken == PRESSURE_AT) begin
        hold_off = 1'b1;
        res_chan.ready <= 1'b0;
        repeat (PRESSURE_LEN) @(posedge clk);
        hold_off = 1'b0;
        pressure_done = 1'b1;
      end else begin
        if ((results_taken / 64) % 4 == 1)
          k = 0;
        else
          k = $urandom_range(0, MAX_GAP);
        if (k != 0) begin
          res_chan.ready <= 1'b0;
          repeat (k) @(posedge clk);
        end
      end
      res_chan.ready <= 1'b1;
      do @(posedge clk); while (!(res_chan.valid === 1'b1 && res_chan.ready === 1'b1));
      results_taken++;
    end
  end

  // Watchdog for a hung run
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/lrr_pkg.sv
hw/rtl/lrr_in_if.sv
hw/rtl/lrr_out_if.sv
hw/rtl/lrr_front.sv
hw/rtl/lrr_queue.sv
hw/rtl/lrr_rem_unit.sv
hw/rtl/lrr_back.sv
hw/rtl/lehmer_random_ranged.sv
sim/lrr_checker.sv
sim/tb_top.sv
